// ===== sv/one_wire_temp_sensor_master_unit_macros.svh =====
// ----------------------------------------------------------------------------
// One-wire master assertion macros
// Immediate-implication and next-cycle-implication property shorthands.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_TEMP_SENSOR_MASTER_UNIT_MACROS_SVH
`define ONE_WIRE_TEMP_SENSOR_MASTER_UNIT_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define OWTS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define OWTS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/owts_pkg.sv =====
// ----------------------------------------------------------------------------
// One-wire master package
// Bus phases, command and sequence codes, register map and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package owts_pkg;

  // Input command codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_RESET = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_TEMP  = 3'd4;

  // Bus command bytes
  localparam logic [7:0] CMD_SKIP_ROM = 8'hcc;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hbe;

  // Temperature sequence steps
  localparam logic [3:0] STEP_RST_A     = 4'd0;
  localparam logic [3:0] STEP_SKIP_A    = 4'd1;
  localparam logic [3:0] STEP_CONVERT   = 4'd2;
  localparam logic [3:0] STEP_CONV_WAIT = 4'd3;
  localparam logic [3:0] STEP_RST_B     = 4'd4;
  localparam logic [3:0] STEP_SKIP_B    = 4'd5;
  localparam logic [3:0] STEP_READ_SP   = 4'd6;
  localparam logic [3:0] STEP_READ_LO   = 4'd7;
  localparam logic [3:0] STEP_READ_HI   = 4'd8;
  localparam logic [3:0] SEQ_STANDALONE = 4'd15;

  // Fixed release time after the reset pulse
  localparam logic [19:0] RELEASE_US = 20'd15;

  // Register map
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_RESET_LOW    = 3'd0;
  localparam logic [2:0] REG_PRES_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_AFTER_PRES   = 3'd2;
  localparam logic [2:0] REG_ONE_LOW      = 3'd3;
  localparam logic [2:0] REG_ZERO_LOW     = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE  = 3'd5;
  localparam logic [2:0] REG_SLOT         = 3'd6;
  localparam logic [2:0] REG_CONVERT_WAIT = 3'd7;

  typedef enum logic [8:0] {
    PH_IDLE      = 9'b000000001,
    PH_RST_LOW   = 9'b000000010,
    PH_RST_REL   = 9'b000000100,
    PH_PRES_WAIT = 9'b000001000,
    PH_PRES_LOW  = 9'b000010000,
    PH_AFTER     = 9'b000100000,
    PH_WSLOT     = 9'b001000000,
    PH_RSLOT     = 9'b010000000,
    PH_CONV      = 9'b100000000
  } owts_phase_t;

  typedef struct packed {
    logic [9:0]  reset_low;
    logic [7:0]  presence_timeout;
    logic [9:0]  after_presence;
    logic [5:0]  one_low;
    logic [6:0]  zero_low;
    logic [5:0]  read_sample;
    logic [6:0]  slot;
    logic [19:0] convert_wait;
  } owts_cfg_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        presence;
    logic [15:0] read_value;
  } owts_res_t;

  typedef struct packed {
    owts_phase_t phase;
    logic [7:0]  shift;
    logic [2:0]  bidx;
  } owts_launch_t;

  // Pick the phase and shifter load that open a temperature sequence step
  function automatic owts_launch_t owts_launch(input logic [3:0] step,
                                               input logic [7:0] shift,
                                               input logic [2:0] bidx);
    owts_launch_t l;
    l.phase = PH_RSLOT;
    l.shift = 8'h00;
    l.bidx  = 3'd0;
    case (step)
      STEP_RST_A, STEP_RST_B: begin
        l.phase = PH_RST_LOW;
        l.shift = shift;
        l.bidx  = bidx;
      end
      STEP_SKIP_A, STEP_SKIP_B: begin
        l.phase = PH_WSLOT;
        l.shift = CMD_SKIP_ROM;
      end
      STEP_CONVERT: begin
        l.phase = PH_WSLOT;
        l.shift = CMD_CONVERT;
      end
      STEP_CONV_WAIT: begin
        l.phase = PH_CONV;
        l.shift = shift;
        l.bidx  = bidx;
      end
      STEP_READ_SP: begin
        l.phase = PH_WSLOT;
        l.shift = CMD_READ_SP;
      end
      default: begin
        l.phase = PH_RSLOT;
      end
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ===== sv/owts_if.sv =====
// ----------------------------------------------------------------------------
// One-wire master channels
// Valid/ready word channels for tick commands and bus results.
// ----------------------------------------------------------------------------
`default_nettype none

interface owts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] data_byte;
  logic       line_level;

  modport source (output valid, output op, output data_byte, output line_level,
                  input ready);
  modport sink (input valid, input op, input data_byte, input line_level,
                output ready);
endinterface

interface owts_out_if;
  logic        valid;
  logic        ready;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic        presence;
  logic [15:0] read_value;

  modport source (output valid, output drive_low, output busy_res,
                  output done_res, output presence, output read_value,
                  input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input presence, input read_value, output ready);
endinterface

`default_nettype wire

// ===== sv/owts_cfg.sv =====
// ----------------------------------------------------------------------------
// One-wire master register file
// APB-style timing registers with reset defaults and read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module owts_cfg
  import owts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output owts_cfg_t              cfg
);

  owts_cfg_t  cfg_r;
  owts_cfg_t  cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Update the addressed register on a write access
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_RESET_LOW:    cfg_nxt.reset_low        = pwdata[9:0];
        REG_PRES_TIMEOUT: cfg_nxt.presence_timeout = pwdata[7:0];
        REG_AFTER_PRES:   cfg_nxt.after_presence   = pwdata[9:0];
        REG_ONE_LOW:      cfg_nxt.one_low          = pwdata[5:0];
        REG_ZERO_LOW:     cfg_nxt.zero_low         = pwdata[6:0];
        REG_READ_SAMPLE:  cfg_nxt.read_sample      = pwdata[5:0];
        REG_SLOT:         cfg_nxt.slot             = pwdata[6:0];
        REG_CONVERT_WAIT: cfg_nxt.convert_wait     = pwdata[19:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low        <= 10'd750;
      cfg_r.presence_timeout <= 8'd100;
      cfg_r.after_presence   <= 10'd240;
      cfg_r.one_low          <= 6'd8;
      cfg_r.zero_low         <= 7'd70;
      cfg_r.read_sample      <= 6'd5;
      cfg_r.slot             <= 7'd72;
      cfg_r.convert_wait     <= 20'd750000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Return the addressed register, zero extended
  always_comb begin
    case (idx)
      REG_RESET_LOW:    prdata = {22'd0, cfg_r.reset_low};
      REG_PRES_TIMEOUT: prdata = {24'd0, cfg_r.presence_timeout};
      REG_AFTER_PRES:   prdata = {22'd0, cfg_r.after_presence};
      REG_ONE_LOW:      prdata = {26'd0, cfg_r.one_low};
      REG_ZERO_LOW:     prdata = {25'd0, cfg_r.zero_low};
      REG_READ_SAMPLE:  prdata = {26'd0, cfg_r.read_sample};
      REG_SLOT:         prdata = {25'd0, cfg_r.slot};
      REG_CONVERT_WAIT: prdata = {12'd0, cfg_r.convert_wait};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/owts_core.sv =====
// ----------------------------------------------------------------------------
// One-wire master bus engine
// Phase state, timers and shifter; one tick of bus timing per step.
// ----------------------------------------------------------------------------
`default_nettype none

module owts_core
  import owts_pkg::*;
#(
  parameter int TIMER_BITS = 20
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [2:0] op,
  input  wire logic [7:0] data_byte,
  input  wire logic       line_level,
  input  wire owts_cfg_t  cfg,
  output owts_res_t       res
);

  localparam int TW = TIMER_BITS;
  localparam int DW = TIMER_BITS + 21;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  owts_phase_t   phase_r, phase_nxt;
  logic [TW-1:0] tmr_r, tmr_nxt;
  logic [2:0]    bidx_r, bidx_nxt;
  logic [7:0]    sh_r, sh_nxt;
  logic [3:0]    seq_r, seq_nxt;
  logic [15:0]   val_r, val_nxt;
  logic          pres_r, pres_nxt;
  logic          drive_c, done_c;

  // Advance the timer, saturating at its top value
  function automatic logic [TW-1:0] tmr_inc(input logic [TW-1:0] t);
    return (t == TMAX) ? t : t + TW'(1);
  endfunction

  // Compare an advanced timer against a clipped duration of at least one
  function automatic logic tmr_hit(input logic [TW-1:0] t, input logic [19:0] d);
    logic [DW-1:0] lim;
    logic [DW-1:0] dw;
    lim = DW'(TMAX);
    dw  = DW'(d);
    if (dw > lim) dw = lim;
    if (dw == '0) dw = DW'(1);
    return DW'(t) >= dw;
  endfunction

  // Take up a command when idle, then run one tick of the bus phase
  always_comb begin
    owts_launch_t  l;
    logic [TW-1:0] ti;
    logic          finish;
    logic          rd;
    logic [6:0]    lo;
    logic [7:0]    t8;
    logic          slot_end;

    phase_nxt = phase_r;
    tmr_nxt   = tmr_r;
    bidx_nxt  = bidx_r;
    sh_nxt    = sh_r;
    seq_nxt   = seq_r;
    val_nxt   = val_r;
    pres_nxt  = pres_r;
    drive_c   = 1'b0;
    done_c    = 1'b0;
    finish    = 1'b0;
    l         = '{phase: PH_IDLE, shift: 8'h00, bidx: 3'd0};
    rd        = 1'b0;
    lo        = 7'd0;
    t8        = 8'd0;
    slot_end  = 1'b0;

    if (phase_r == PH_IDLE) begin
      case (op)
        OP_RESET: begin
          seq_nxt   = SEQ_STANDALONE;
          phase_nxt = PH_RST_LOW;
          tmr_nxt   = '0;
        end
        OP_WRITE: begin
          seq_nxt   = SEQ_STANDALONE;
          phase_nxt = PH_WSLOT;
          sh_nxt    = data_byte;
          bidx_nxt  = 3'd0;
          tmr_nxt   = '0;
        end
        OP_READ: begin
          seq_nxt   = SEQ_STANDALONE;
          phase_nxt = PH_RSLOT;
          sh_nxt    = 8'h00;
          bidx_nxt  = 3'd0;
          tmr_nxt   = '0;
        end
        OP_TEMP: begin
          seq_nxt   = STEP_RST_A;
          phase_nxt = PH_RST_LOW;
          tmr_nxt   = '0;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    ti = tmr_inc(tmr_nxt);

    case (phase_nxt)
      PH_IDLE: begin
        drive_c = 1'b0;
      end
      PH_RST_LOW: begin
        drive_c = 1'b1;
        tmr_nxt = ti;
        if (tmr_hit(ti, 20'(cfg.reset_low))) begin
          phase_nxt = PH_RST_REL;
          tmr_nxt   = '0;
        end
      end
      PH_RST_REL: begin
        tmr_nxt = ti;
        if (tmr_hit(ti, RELEASE_US)) begin
          phase_nxt = PH_PRES_WAIT;
          tmr_nxt   = '0;
        end
      end
      PH_PRES_WAIT: begin
        if (!line_level) begin
          pres_nxt  = 1'b1;
          phase_nxt = PH_PRES_LOW;
          tmr_nxt   = '0;
        end else begin
          tmr_nxt = ti;
          if (tmr_hit(ti, 20'(cfg.presence_timeout))) begin
            pres_nxt  = 1'b0;
            phase_nxt = PH_AFTER;
            tmr_nxt   = '0;
          end
        end
      end
      PH_PRES_LOW: begin
        tmr_nxt = ti;
        if (line_level || tmr_hit(ti, 20'(cfg.presence_timeout))) begin
          phase_nxt = PH_AFTER;
          tmr_nxt   = '0;
        end
      end
      PH_AFTER: begin
        tmr_nxt = ti;
        finish  = tmr_hit(ti, 20'(cfg.after_presence));
      end
      PH_CONV: begin
        tmr_nxt = ti;
        finish  = tmr_hit(ti, cfg.convert_wait);
      end
      PH_WSLOT, PH_RSLOT: begin
        rd = (phase_nxt == PH_RSLOT);
        t8 = tmr_nxt[7:0];
        if (rd) lo = {1'b0, cfg.read_sample};
        else if (sh_nxt[0]) lo = {1'b0, cfg.one_low};
        else lo = cfg.zero_low;
        drive_c = (t8 < {1'b0, lo});
        // Sample on the first released tick of a read slot
        if (rd && (t8 == {1'b0, lo})) sh_nxt = {line_level, sh_nxt[7:1]};
        slot_end = ((9'(t8) + 9'd1) >= 9'(cfg.slot)) && (t8 >= {1'b0, lo});
        tmr_nxt  = tmr_nxt + TW'(1);
        if (slot_end) begin
          tmr_nxt = '0;
          if (!rd) sh_nxt = {1'b0, sh_nxt[7:1]};
          if (bidx_nxt < 3'd7) begin
            bidx_nxt = bidx_nxt + 3'd1;
          end else begin
            bidx_nxt = 3'd0;
            if (rd) begin
              if (seq_nxt == STEP_READ_HI) val_nxt = {sh_nxt, val_nxt[7:0]};
              else val_nxt = {8'h00, sh_nxt};
            end
            finish = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tmr_nxt   = '0;
      end
    endcase

    // Close the command or open the next sequence step
    if (finish) begin
      if ((seq_nxt == SEQ_STANDALONE) || (seq_nxt >= STEP_READ_HI)) begin
        phase_nxt = PH_IDLE;
        tmr_nxt   = '0;
        done_c    = 1'b1;
      end else begin
        seq_nxt   = seq_nxt + 4'd1;
        l         = owts_launch(seq_nxt, sh_nxt, bidx_nxt);
        phase_nxt = l.phase;
        sh_nxt    = l.shift;
        bidx_nxt  = l.bidx;
        tmr_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tmr_r   <= '0;
      bidx_r  <= 3'd0;
      sh_r    <= 8'h00;
      seq_r   <= 4'd0;
      val_r   <= 16'h0000;
      pres_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tmr_r   <= tmr_nxt;
      bidx_r  <= bidx_nxt;
      sh_r    <= sh_nxt;
      seq_r   <= seq_nxt;
      val_r   <= val_nxt;
      pres_r  <= pres_nxt;
    end
  end

  assign res.drive_low  = drive_c;
  assign res.busy_res   = (phase_nxt != PH_IDLE);
  assign res.done_res   = done_c;
  assign res.presence   = pres_nxt;
  assign res.read_value = val_nxt;

endmodule

`default_nettype wire

// ===== sv/one_wire_temp_sensor_master_unit.sv =====
// ----------------------------------------------------------------------------
// One-wire temperature sensor bus master
// Tick-driven one-wire master: reset/presence, byte write and read, and a
// full temperature read sequence, with APB-style timing registers.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+------------------------------------------
//  in_if   | in  | valid/ready      | op, data_byte, line_level (one tick)
//  out_if  | out | valid/ready      | drive_low, busy_res, done_res, presence,
//          |     |                  | read_value (one per tick)
//  apb     | in  | psel/penable     | timing registers at 4*index
//
//  One word per clock sustained while out_if.ready stays high; an accepted
//  word passes through the input register, then the single-pass bus engine
//  into the result register, whose load raises out_if.valid.
//  rst_n is synchronous: it clears the bus phase, flags, valid bits and
//  loads the register defaults. No clearing pass follows reset.
//  A stalled result holds in the output register; one more word waits in
//  the input register, after which in_if.ready drops.
//
`default_nettype none

`include "one_wire_temp_sensor_master_unit_macros.svh"

module one_wire_temp_sensor_master_unit
  import owts_pkg::*;
#(
  parameter int TIMER_BITS = 20
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  owts_in_if.sink                in_if,
  owts_out_if.source             out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  owts_cfg_t  cfg;
  owts_res_t  res_c;

  logic       in_v_r, in_v_nxt;
  logic [2:0] in_op_r;
  logic [7:0] in_data_r;
  logic       in_line_r;
  logic       out_v_r, out_v_nxt;
  owts_res_t  out_res_r;
  logic       adv;
  logic       in_take;

  owts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owts_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .op         (in_op_r),
    .data_byte  (in_data_r),
    .line_level (in_line_r),
    .cfg        (cfg),
    .res        (res_c)
  );

  // Move a held word into the engine when the result register frees up
  assign adv         = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || adv;
  assign in_take     = in_if.valid && in_if.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) in_v_nxt = 1'b1;
    else if (adv) in_v_nxt = 1'b0;
    out_v_nxt = out_v_r;
    if (adv) out_v_nxt = 1'b1;
    else if (out_if.ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Hold the input word and the result word
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r   <= in_if.op;
      in_data_r <= in_if.data_byte;
      in_line_r <= in_if.line_level;
    end
    if (adv) out_res_r <= res_c;
  end

  assign out_if.valid      = out_v_r;
  assign out_if.drive_low  = out_res_r.drive_low;
  assign out_if.busy_res   = out_res_r.busy_res;
  assign out_if.done_res   = out_res_r.done_res;
  assign out_if.presence   = out_res_r.presence;
  assign out_if.read_value = out_res_r.read_value;

  `OWTS_ASSERT_NOW(a_ready_low, clk, rst_n, !in_if.ready, in_v_r && out_v_r && !out_if.ready, "input stalled without full pipe")
  `OWTS_ASSERT_NEXT(a_adv_fill, clk, rst_n, adv, out_v_r, "advanced word produced no result")
  `OWTS_ASSERT_NOW(a_done_idle, clk, rst_n, out_v_r && out_if.done_res, !out_if.busy_res, "done reported while busy")
  `OWTS_ASSERT_NOW(a_drive_busy, clk, rst_n, out_v_r && out_if.drive_low, out_if.busy_res, "bus driven low while idle")

endmodule

`default_nettype wire
